>>> sv/qalu_pkg.sv
// Shared types, operation and status codes, and the Hamilton product term tables
// for the quaternion ALU. No dependencies; every other file but qalu_if uses it.
`default_nettype none

package qalu_pkg;

	localparam int FRAC_BITS_DEF   = 28;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Bit position at which the normalize path places the largest magnitude.
	localparam int SCALE_MSB   = 29;
	// One stage per root bit; the sum of squares stays below 2^62.
	localparam int SQRT_STEPS  = 31;

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_CONJ = 2'd2;
	localparam logic [1:0] OP_NORM = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	// Product term t of result part c sits at index 4*c+t.
	localparam logic [1:0] PROD_A [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd2, 2'd3, 2'd1,
		2'd0, 2'd3, 2'd1, 2'd2};
	localparam logic [1:0] PROD_B [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd2, 2'd1};
	localparam logic PROD_NEG [16] = '{
		1'b0, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b1};

	// A classified request as it waits in the queue.
	typedef struct packed {
		logic [1:0]       op;
		logic [3:0][31:0] a;
		logic [3:0][31:0] b;
		logic [3:0][31:0] mag;
		logic [3:0]       neg;
		logic             zero;
	} qalu_item_t;

	// Returns {saturated, clamped value} for a 33-bit signed sum.
	function automatic logic [32:0] clamp33(input logic [32:0] v);
		logic sat;
		sat = v[32] ^ v[31];
		if (sat) begin
			return {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
		end
		return {1'b0, v[31:0]};
	endfunction

endpackage

`default_nettype wire

>>> sv/qalu_if.sv
// Valid/ready channel interfaces for the quaternion ALU requests and results.
// No dependencies.
`default_nettype none

interface qalu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] a_scalar;
	logic [31:0] a_i;
	logic [31:0] a_j;
	logic [31:0] a_k;
	logic [31:0] b_scalar;
	logic [31:0] b_i;
	logic [31:0] b_j;
	logic [31:0] b_k;

	modport source (output valid, req_type, a_scalar, a_i, a_j, a_k,
		b_scalar, b_i, b_j, b_k, input ready);
	modport sink (input valid, req_type, a_scalar, a_i, a_j, a_k,
		b_scalar, b_i, b_j, b_k, output ready);
endinterface

interface qalu_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] r_scalar;
	logic [31:0] r_i;
	logic [31:0] r_j;
	logic [31:0] r_k;
	logic [1:0]  status;

	modport source (output valid, r_scalar, r_i, r_j, r_k, status, input ready);
	modport sink (input valid, r_scalar, r_i, r_j, r_k, status, output ready);
endinterface

`default_nettype wire

>>> sv/quaternion_alu_unit.sv
// Quaternion ALU top level: front end, queue and arithmetic back end.
// Uses qalu_pkg, qalu_if, qalu_front, qalu_queue and qalu_back.
//
// Each request beat carries an operation code and two Q3.28 quaternions A and B;
// the unit answers with one result beat holding the Hamilton product, the
// saturating sum, the conjugate of A or A scaled to unit length, plus a status
// (ok, saturated, or zero norm on normalize). Results leave in request order.
// A new request is taken every cycle while the result side keeps up. Every
// operation passes through the 31-stage square root and the FRAC_BITS + 1 stage
// divider of normalize, so that order is kept. A stalled result stalls the back
// end as a whole, and the queue then absorbs up to QUEUE_DEPTH requests.
`default_nettype none

module quaternion_alu_unit #(
	parameter int FRAC_BITS   = qalu_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qalu_req_if.sink   req,
	qalu_rsp_if.source rsp
);
	import qalu_pkg::*;

	qalu_item_t push_item;
	qalu_item_t head;
	logic       push;
	logic       full;
	logic       pop;
	logic       head_valid;

	qalu_front u_front (
		.req  (req),
		.full (full),
		.push (push),
		.item (push_item)
	);

	qalu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	qalu_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp        (rsp)
	);

endmodule

`default_nettype wire

>>> sv/qalu_front.sv
// Request front end: takes beats from the request channel, works out signs,
// magnitudes and the zero case, and pushes them into the queue. Uses qalu_pkg.
`default_nettype none

module qalu_front (
	qalu_req_if.sink          req,
	input  wire logic         full,
	output logic              push,
	output qalu_pkg::qalu_item_t item
);
	import qalu_pkg::*;

	logic [3:0][31:0] a_w;

	assign a_w       = {req.a_k, req.a_j, req.a_i, req.a_scalar};
	assign req.ready = ~full;
	assign push      = req.valid & ~full;

	always_comb begin
		item      = '0;
		item.op   = req.req_type;
		item.a    = a_w;
		item.b    = {req.b_k, req.b_j, req.b_i, req.b_scalar};
		for (int c = 0; c < 4; c++) begin
			item.neg[c] = a_w[c][31];
			// The most negative part gives 2^31, which still fits unsigned.
			item.mag[c] = a_w[c][31] ? (32'd0 - a_w[c]) : a_w[c];
		end
		item.zero = (a_w == '0);
	end

endmodule

`default_nettype wire

>>> sv/qalu_queue.sv
// Short queue between the front end and the arithmetic back end.
// Uses qalu_pkg for the item type.
`default_nettype none

module qalu_queue #(
	parameter int DEPTH = qalu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  qalu_pkg::qalu_item_t      push_item,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      head_valid,
	output qalu_pkg::qalu_item_t      head
);
	import qalu_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qalu_item_t       mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/qalu_back.sv
// Arithmetic back end: product, sum, conjugate and a pipelined square root and
// divider for normalize, with the result register. Uses qalu_pkg and qalu_rsp_if.
`default_nettype none

module qalu_back #(
	parameter int FRAC_BITS = qalu_pkg::FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  qalu_pkg::qalu_item_t head,
	output logic                 pop,
	qalu_rsp_if.source           rsp
);
	import qalu_pkg::*;

	localparam int QB   = FRAC_BITS + 1;
	localparam int NUMW = SCALE_MSB + 2 + FRAC_BITS;
	localparam int SQ   = SQRT_STEPS;
	localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);

	typedef struct packed {
		logic [1:0]       op;
		logic             sat;
		logic             zero;
		logic [3:0]       neg;
		logic [3:0][31:0] res;
		logic [3:0][29:0] s;
	} carry_t;

	logic adv;
	logic out_v_q;
	logic [3:0][31:0] res_q;
	logic [1:0]       status_q;

	// The whole pipeline moves as one whenever the result register can take a beat.
	assign adv = ~out_v_q | rsp.ready;
	assign pop = head_valid & adv;

	assign rsp.valid    = out_v_q;
	assign rsp.r_scalar = res_q[0];
	assign rsp.r_i      = res_q[1];
	assign rsp.r_j      = res_q[2];
	assign rsp.r_k      = res_q[3];
	assign rsp.status   = status_q;

	// Stage 1: raw products, sum and conjugate, largest magnitude.
	carry_t c1;
	logic [31:0] mx;
	logic [32:0] cl;

	always_comb begin
		c1      = '0;
		c1.op   = head.op;
		c1.zero = head.zero;
		c1.neg  = head.neg;
		cl      = '0;
		case (head.op)
			OP_ADD: begin
				for (int c = 0; c < 4; c++) begin
					cl = clamp33({head.a[c][31], head.a[c]} + {head.b[c][31], head.b[c]});
					c1.res[c] = cl[31:0];
					c1.sat    = c1.sat | cl[32];
				end
			end
			OP_CONJ: begin
				c1.res[0] = head.a[0];
				for (int c = 1; c < 4; c++) begin
					cl = clamp33(33'd0 - {head.a[c][31], head.a[c]});
					c1.res[c] = cl[31:0];
					c1.sat    = c1.sat | cl[32];
				end
			end
			default: begin
			end
		endcase
		mx = head.mag[0];
		for (int c = 1; c < 4; c++) begin
			if (head.mag[c] > mx) begin
				mx = head.mag[c];
			end
		end
	end

	logic               v_s1;
	carry_t             cr_s1;
	logic signed [63:0] prod_s1 [16];
	logic [3:0][31:0]   mag_s1;
	logic [31:0]        mx_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s1  <= c1;
			mag_s1 <= head.mag;
			mx_s1  <= mx;
			for (int i = 0; i < 16; i++) begin
				prod_s1[i] <= $signed(head.a[PROD_A[i]]) * $signed(head.b[PROD_B[i]]);
			end
		end
	end

	// Stage 2: signed pair sums of the products; power-of-two scaling of A.
	logic signed [64:0] term [16];
	logic [4:0]         pos;
	logic [4:0]         lsh;
	logic [1:0]         rsh;
	carry_t             c2;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			term[i] = PROD_NEG[i] ? -(65'(prod_s1[i])) : 65'(prod_s1[i]);
		end
		pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (mx_s1[i]) begin
				pos = 5'(i);
			end
		end
		lsh = (pos < 5'(SCALE_MSB)) ? 5'(SCALE_MSB) - pos : 5'd0;
		rsh = (pos > 5'(SCALE_MSB)) ? 2'(pos - 5'(SCALE_MSB)) : 2'd0;
		c2  = cr_s1;
		for (int c = 0; c < 4; c++) begin
			c2.s[c] = 30'(((64'(mag_s1[c])) << lsh) >> rsh);
		end
	end

	logic               v_s2;
	carry_t             cr_s2;
	logic signed [65:0] ps_s2 [4][2];

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s2 <= c2;
			for (int c = 0; c < 4; c++) begin
				ps_s2[c][0] <= 66'(term[4*c])     + 66'(term[4*c + 1]);
				ps_s2[c][1] <= 66'(term[4*c + 2]) + 66'(term[4*c + 3]);
			end
		end
	end

	// Stage 3: full sums with the rounding half added; squares of the scaled parts.
	logic               v_s3;
	carry_t             cr_s3;
	logic signed [66:0] tot_s3 [4];
	logic [59:0]        sq_s3 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s3 <= cr_s2;
			for (int c = 0; c < 4; c++) begin
				tot_s3[c] <= 67'(ps_s2[c][0]) + 67'(ps_s2[c][1]) + HALF;
				sq_s3[c]  <= cr_s2.s[c] * cr_s2.s[c];
			end
		end
	end

	// Stage 4: rounded and clamped product; sum of squares.
	logic signed [66:0] rnd [4];
	carry_t             c4;
	logic               rsat;

	always_comb begin
		c4   = cr_s3;
		rsat = 1'b0;
		for (int c = 0; c < 4; c++) begin
			rnd[c] = tot_s3[c] >>> FRAC_BITS;
			rsat   = ~((&rnd[c][66:31]) | ~(|rnd[c][66:31]));
			if (cr_s3.op == OP_MUL) begin
				c4.res[c] = rsat ? (rnd[c][66] ? 32'h8000_0000 : 32'h7FFF_FFFF)
					: rnd[c][31:0];
				c4.sat    = c4.sat | rsat;
			end
		end
	end

	logic        v_s4;
	carry_t      cr_s4;
	logic [61:0] sum_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			cr_s4  <= c4;
			sum_s4 <= 62'(sq_s3[0]) + 62'(sq_s3[1]) + 62'(sq_s3[2]) + 62'(sq_s3[3]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Square root, one root bit per stage by the remainder method.
	logic        sq_v    [SQ+1];
	logic [62:0] sq_rem  [SQ+1];
	logic [62:0] sq_root [SQ+1];
	carry_t      sq_cr   [SQ+1];

	assign sq_v[0]    = v_s4;
	assign sq_rem[0]  = 63'(sum_s4);
	assign sq_root[0] = '0;
	assign sq_cr[0]   = cr_s4;

	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		localparam int K = SQ - 1 - j;
		localparam logic [62:0] BITV = 63'd1 << (2 * K);
		logic [62:0] trial;
		assign trial = sq_root[j] + BITV;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[j+1] <= 1'b0;
			end else if (adv) begin
				sq_v[j+1] <= sq_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_cr[j+1] <= sq_cr[j];
				if (sq_rem[j] >= trial) begin
					sq_rem[j+1]  <= sq_rem[j] - trial;
					sq_root[j+1] <= (sq_root[j] >> 1) + BITV;
				end else begin
					sq_rem[j+1]  <= sq_rem[j];
					sq_root[j+1] <= sq_root[j] >> 1;
				end
			end
		end
	end

	// Divider: four lanes of restoring division, one quotient bit per stage.
	logic            dv_v   [QB+1];
	logic [30:0]     dv_n   [QB+1];
	carry_t          dv_cr  [QB+1];
	logic [NUMW-1:0] dv_rem [QB+1][4];
	logic [QB-1:0]   dv_q   [QB+1][4];
	logic [30:0]     root_n;

	assign root_n = sq_root[SQ][30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= sq_v[SQ];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_n[0]  <= root_n;
			dv_cr[0] <= sq_cr[SQ];
			for (int l = 0; l < 4; l++) begin
				dv_rem[0][l] <= (NUMW'(sq_cr[SQ].s[l]) << FRAC_BITS) + NUMW'(root_n >> 1);
				dv_q[0][l]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int B = QB - 1 - j;
		logic [NUMW-1:0] dvs;
		assign dvs = NUMW'(dv_n[j]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_n[j+1]  <= dv_n[j];
				dv_cr[j+1] <= dv_cr[j];
				for (int l = 0; l < 4; l++) begin
					if (dv_rem[j][l] >= dvs) begin
						dv_rem[j+1][l]  <= dv_rem[j][l] - dvs;
						dv_q[j+1][l]    <= dv_q[j][l] | (QB'(1) << B);
					end else begin
						dv_rem[j+1][l]  <= dv_rem[j][l];
						dv_q[j+1][l]    <= dv_q[j][l];
					end
				end
			end
		end
	end

	// Result selection into the output register.
	logic [3:0][31:0] fin;
	logic [1:0]       fin_st;
	carry_t           cf;

	always_comb begin
		cf = dv_cr[QB];
		if (cf.op == OP_NORM) begin
			fin_st = cf.zero ? ST_ZERO : ST_OK;
			for (int l = 0; l < 4; l++) begin
				if (cf.zero) begin
					fin[l] = '0;
				end else if (cf.neg[l]) begin
					fin[l] = 32'd0 - 32'(dv_q[QB][l]);
				end else begin
					fin[l] = 32'(dv_q[QB][l]);
				end
			end
		end else begin
			fin    = cf.res;
			fin_st = cf.sat ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q    <= fin;
			status_q <= fin_st;
		end
	end

endmodule

`default_nettype wire

>>> dv/qalu_checker.sv
// Checker for the quaternion ALU: watches request and result beats, predicts each result
// and compares it field by field. Depends on qalu_pkg and qalu_if.
`default_nettype none

module qalu_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	qalu_req_if       req,
	qalu_rsp_if       rsp,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import qalu_pkg::*;

	localparam int FB = FRAC_BITS_DEF;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] i;
		logic [31:0] j;
		logic [31:0] k;
		logic [1:0]  st;
	} quat_res_t;

	quat_res_t expected_results[$];

	function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
			inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic quat_res_t compute_quat(input logic [1:0] op,
			input logic [3:0][31:0] av, input logic [3:0][31:0] bv);
		logic signed [63:0] a [4];
		logic signed [63:0] b [4];
		logic signed [63:0] r [4];
		logic signed [127:0] acc;
		logic [63:0] m [4];
		logic [63:0] mx, sum, n, q;
		logic sat;
		logic [1:0] st;
		int c, t, xa, xb;
		quat_res_t res;
		sat = 1'b0;
		st = ST_OK;
		for (c = 0; c < 4; c++) begin
			a[c] = $signed(av[c]);
			b[c] = $signed(bv[c]);
			r[c] = 0;
		end
		case (op)
			OP_MUL: begin
				for (c = 0; c < 4; c++) begin
					acc = 0;
					for (t = 0; t < 4; t++) begin
						xa = PROD_A[4*c+t];
						xb = PROD_B[4*c+t];
						if (PROD_NEG[4*c+t]) acc = acc - a[xa] * b[xb];
						else acc = acc + a[xa] * b[xb];
					end
					// Round to nearest, ties upwards, via an arithmetic shift.
					acc = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
					r[c] = clamp_word(acc[63:0], sat);
				end
			end
			OP_ADD: begin
				for (c = 0; c < 4; c++) r[c] = clamp_word(a[c] + b[c], sat);
			end
			OP_CONJ: begin
				r[0] = a[0];
				for (c = 1; c < 4; c++) r[c] = clamp_word(-a[c], sat);
			end
			default: begin
				mx = 0;
				sum = 0;
				for (c = 0; c < 4; c++) begin
					m[c] = a[c] < 0 ? 64'(-a[c]) : 64'(a[c]);
					if (m[c] > mx) mx = m[c];
				end
				if (mx == 0) begin
					st = ST_ZERO;
				end else begin
					while (mx < (64'd1 << 29)) begin
						mx = mx << 1;
						for (c = 0; c < 4; c++) m[c] = m[c] << 1;
					end
					while (mx >= (64'd1 << 30)) begin
						mx = mx >> 1;
						for (c = 0; c < 4; c++) m[c] = m[c] >> 1;
					end
					for (c = 0; c < 4; c++) sum = sum + m[c] * m[c];
					n = int_sqrt(sum);
					for (c = 0; c < 4; c++) begin
						q = ((m[c] << FB) + (n >> 1)) / n;
						r[c] = a[c] < 0 ? -$signed(q) : $signed(q);
					end
				end
			end
		endcase
		if (sat) st = ST_SAT;
		res.s = r[0][31:0];
		res.i = r[1][31:0];
		res.j = r[2][31:0];
		res.k = r[3][31:0];
		res.st = st;
		return res;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		quat_res_t want;
		quat_res_t got;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_results.push_back(compute_quat(req.req_type,
					{req.a_k, req.a_j, req.a_i, req.a_scalar},
					{req.b_k, req.b_j, req.b_i, req.b_scalar}));
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.r_scalar, rsp.r_i, rsp.r_j, rsp.r_k, rsp.status};
				if (expected_results.size() == 0) begin
					if (fail_count < 10) $display("unexpected result beat %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display({"mismatch exp s=%h i=%h j=%h k=%h st=%0d",
								" got s=%h i=%h j=%h k=%h st=%0d"},
								want.s, want.i, want.j, want.k, want.st,
								got.s, got.i, got.j, got.k, got.st);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

`default_nettype wire

>>> dv/quaternion_alu_unit_tb.sv
// Top of the quaternion ALU testbench: clock, reset, request stimulus and result stalls.
// Depends on qalu_pkg, qalu_if, qalu_checker and the quaternion_alu_unit RTL.
`default_nettype none

module quaternion_alu_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qalu_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   phase;  // 0 random idling, 1 no idling, 2 long receiver hold-off

	qalu_req_if req ();
	qalu_rsp_if rsp ();

	quaternion_alu_unit u_top (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));
	qalu_checker u_chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [31:0] pick_part();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return $urandom_range(0, 3) - 1;
			4, 5: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
			6: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_quat(input logic [1:0] op, input logic [3:0][31:0] av,
			input logic [3:0][31:0] bv, input bit may_idle);
		while (may_idle && phase == 0 && $urandom_range(0, 99) < 27) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= op;
		{req.a_k, req.a_j, req.a_i, req.a_scalar} <= av;
		{req.b_k, req.b_j, req.b_i, req.b_scalar} <= bv;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic send_random(input bit may_idle);
		logic [3:0][31:0] av, bv;
		int c;
		for (c = 0; c < 4; c++) begin
			av[c] = pick_part();
			bv[c] = pick_part();
		end
		send_quat(2'($urandom_range(0, 3)), av, bv, may_idle);
	endtask

	// Result side: random stalls, except in the idle-free and hold-off phases.
	initial begin
		int n;
		bit held;
		held = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (phase == 2 && !held) begin
				rsp.ready <= 1'b0;
				for (n = 0; n < 200; n++) @(posedge clk);
				held = 1'b1;
			end
			rsp.ready <= (phase != 0) || ($urandom_range(0, 99) >= 27);
		end
	end

	initial begin
		logic [3:0][31:0] ones, zeros, mins, maxs;
		int n, op;
		phase = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = OP_MUL;
		{req.a_k, req.a_j, req.a_i, req.a_scalar} = '0;
		{req.b_k, req.b_j, req.b_i, req.b_scalar} = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		zeros = '0;
		mins = {4{32'h8000_0000}};
		maxs = {4{32'h7FFF_FFFF}};
		ones = {32'h0, 32'h0, 32'h0, 32'h1000_0000};
		// Directed: extremes, every operation, zero norm, conjugate of the most negative part.
		for (op = 0; op < 4; op++) begin
			send_quat(2'(op), mins, mins, 1);
			send_quat(2'(op), maxs, maxs, 1);
			send_quat(2'(op), mins, maxs, 1);
			send_quat(2'(op), zeros, ones, 1);
			send_quat(2'(op), ones, {32'h1, 32'hFFFF_FFFF, 32'h0800_0000, 32'hF000_0000}, 1);
		end
		send_quat(OP_NORM, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}, zeros, 1);
		send_quat(OP_NORM, {32'h1, 32'h1, 32'h1, 32'h1}, zeros, 1);
		for (n = 0; n < 300; n++) send_random(1);
		// Idle-free stretch, then a long result stall while requests keep coming.
		phase = 1;
		for (n = 0; n < 150; n++) send_random(0);
		phase = 2;
		for (n = 0; n < 100; n++) send_random(0);
		// Pause until every result is back.
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		phase = 0;
		for (n = 0; n < 250; n++) send_random(1);
		req.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule

`default_nettype wire
